[src/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the serial packet deframer
// Request and result payload structs, framing byte values and result codes.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Framing bytes
  localparam logic [7:0] SYN_BYTE  = 8'hFF;
  localparam logic [7:0] STX_BYTE  = 8'h02;
  localparam logic [7:0] ETX_BYTE  = 8'h03;
  localparam logic [7:0] DLE_BYTE  = 8'h10;
  localparam logic [7:0] ADDR_BASE = 8'h41;
  localparam logic [7:0] TYPE_INIT = 8'h49;
  localparam logic [7:0] TYPE_POLL = 8'h50;

  // Request kinds
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_STX   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_NODE_ADDRESS = 1'b0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic [7:0]  packet_address;
    logic [7:0]  packet_type;
    logic [6:0]  body_length;
    logic        for_this_node;
    logic        reply_needed;
    logic [15:0] tx_delay;
    logic [1:0]  error_code;
  } out_t;

  // Parser to output stage: one result and its qualifier
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

[src/spd_parser.sv]
// ----------------------------------------------------------------------------
// spd_parser: framing state machine of the serial packet deframer
// Updates the parse state on each accepted request and presents the result
// it causes, if any, combinationally to the output register.
// ----------------------------------------------------------------------------
module spd_parser
  import spd_pkg::*;
#(
  parameter int MAX_BODY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_t        item,
  input  logic [7:0] node_address,
  output res_t       res
);

  localparam int CW = $clog2(MAX_BODY + 1);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_BODY = 3'd3;
  localparam logic [2:0] PH_ESC  = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [1:0]    syn_count, syn_count_next;
  logic          in_packet, in_packet_next;
  logic [CW-1:0] body_count, body_count_next;
  logic [7:0]    held_address, held_address_next;
  logic [7:0]    held_type, held_type_next;
  logic [7:0]    delay_high_byte, delay_high_byte_next;
  logic [7:0]    delay_low_byte, delay_low_byte_next;
  logic [15:0]   delay_value, delay_value_next;

  logic [CW+6:0] count_ext;
  logic          finish;
  logic          emit_data;
  logic          mine;
  logic          load_delay;

  assign count_ext  = (CW+7)'(body_count);
  assign mine       = (held_address == node_address);
  assign load_delay = mine && (held_type == TYPE_INIT);

  always_comb begin
    phase_next           = phase;
    syn_count_next       = syn_count;
    in_packet_next       = in_packet;
    body_count_next      = body_count;
    held_address_next    = held_address;
    held_type_next       = held_type;
    delay_high_byte_next = delay_high_byte;
    delay_low_byte_next  = delay_low_byte;
    delay_value_next     = delay_value;
    finish               = 1'b0;
    emit_data            = 1'b0;
    res                  = '0;
    res.data.tx_delay    = delay_value;

    if (step) begin
      if (item.req_type == REQ_TIMEOUT) begin
        if (in_packet) begin
          res.valid            = 1'b1;
          res.data.result_kind = KIND_ERROR;
          res.data.error_code  = ERR_TIMEOUT;
          finish               = 1'b1;
        end
      end else begin
        in_packet_next = 1'b1;
        case (phase)
          PH_HUNT: begin
            if (item.rx_byte == SYN_BYTE) begin
              if (syn_count != 2'd2) begin
                syn_count_next = syn_count + 2'd1;
              end
            end else if (syn_count != 2'd2) begin
              syn_count_next = 2'd0;
            end else if (item.rx_byte != STX_BYTE) begin
              res.valid            = 1'b1;
              res.data.result_kind = KIND_ERROR;
              res.data.error_code  = ERR_NO_STX;
              finish               = 1'b1;
            end else begin
              syn_count_next       = 2'd0;
              delay_high_byte_next = 8'd0;
              delay_low_byte_next  = 8'd0;
              body_count_next      = '0;
              phase_next           = PH_ADDR;
            end
          end
          PH_ADDR: begin
            held_address_next = item.rx_byte - ADDR_BASE;
            phase_next        = PH_TYPE;
          end
          PH_TYPE: begin
            held_type_next = item.rx_byte;
            phase_next     = PH_BODY;
          end
          PH_BODY: begin
            if (item.rx_byte == ETX_BYTE) begin
              res.valid               = 1'b1;
              res.data.result_kind    = KIND_COMPLETE;
              res.data.packet_address = held_address;
              res.data.packet_type    = held_type;
              res.data.body_length    = count_ext[6:0];
              res.data.for_this_node  = mine;
              res.data.reply_needed   = mine && (held_type == TYPE_POLL);
              if (load_delay) begin
                delay_value_next  = {delay_high_byte, delay_low_byte};
                res.data.tx_delay = {delay_high_byte, delay_low_byte};
              end
              finish = 1'b1;
            end else if (body_count >= CW'(MAX_BODY)) begin
              res.valid            = 1'b1;
              res.data.result_kind = KIND_ERROR;
              res.data.error_code  = ERR_OVERFLOW;
              finish               = 1'b1;
            end else if (item.rx_byte == DLE_BYTE) begin
              phase_next = PH_ESC;
            end else begin
              emit_data = 1'b1;
            end
          end
          PH_ESC: begin
            emit_data = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      if (emit_data) begin
        res.valid            = 1'b1;
        res.data.result_kind = KIND_DATA;
        res.data.data_byte   = item.rx_byte;
        res.data.byte_index  = count_ext[5:0];
        if (body_count == CW'(1)) begin
          delay_high_byte_next = item.rx_byte;
        end
        if (body_count == CW'(2)) begin
          delay_low_byte_next = item.rx_byte;
        end
        body_count_next = body_count + CW'(1);
        phase_next      = PH_BODY;
      end

      if (finish) begin
        phase_next      = PH_HUNT;
        syn_count_next  = 2'd0;
        in_packet_next  = 1'b0;
        body_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      syn_count       <= 2'd0;
      in_packet       <= 1'b0;
      body_count      <= '0;
      held_address    <= 8'd0;
      held_type       <= 8'd0;
      delay_high_byte <= 8'd0;
      delay_low_byte  <= 8'd0;
      delay_value     <= 16'd0;
    end else begin
      phase           <= phase_next;
      syn_count       <= syn_count_next;
      in_packet       <= in_packet_next;
      body_count      <= body_count_next;
      held_address    <= held_address_next;
      held_type       <= held_type_next;
      delay_high_byte <= delay_high_byte_next;
      delay_low_byte  <= delay_low_byte_next;
      delay_value     <= delay_value_next;
    end
  end

endmodule

[src/serial_packet_deframer.sv]
// ----------------------------------------------------------------------------
// serial_packet_deframer: byte-stream packet deframer for a serial node link
// A result is registered into out_data, or into the skid entry while stalled.
// One request per cycle while in_ready is high; single-pass state update.
// A two-entry output stage (result register plus skid) keeps in_ready high
// while one result waits, so in_ready drops only when both entries are full.
// Reset (rst, synchronous): parser to sync hunting, node_addr and delay to
// zero, output stage empty.
// ----------------------------------------------------------------------------
module serial_packet_deframer
  import spd_pkg::*;
#(
  parameter int MAX_BODY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       node_address;
  logic [7:0] node_addr;
  logic       step;
  res_t       res;
  logic       skid_valid;
  out_t       skid_data;
  logic       cfg_write;

  // Configuration register: one byte at address 0, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign node_address = (paddr[2] == REG_NODE_ADDRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr <= 8'd0;
    end else if (cfg_write && node_address) begin
      node_addr <= pwdata[7:0];
    end
  end

  // Read back the node address; unmapped addresses read as zero
  always_comb begin
    prdata = 32'd0;
    if (node_address) begin
      prdata = 32'(node_addr);
    end
  end

  // Accept requests until the skid entry is occupied
  assign in_ready = !skid_valid;
  assign step     = in_valid && in_ready;

  spd_parser #(
    .MAX_BODY(MAX_BODY)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_data),
    .node_address(node_addr),
    .res         (res)
  );

  // Output stage: when the result register is free, refill it from the skid
  // entry first, else from the parser; when it is stalled, park any new
  // result in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res.valid) begin
        out_data <= res.data;
      end
    end else if (res.valid) begin
      skid_data <= res.data;
    end
  end

  // The skid entry is only ever filled behind a stalled result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the result register is empty");

  // A new skid entry means the result register was stalled on the last edge
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without a stalled result");

  // Error results carry a code, the others never do
  a_err_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.result_kind == KIND_ERROR) == (out_data.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // No result is produced while the skid entry is full
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !res.valid)
    else $error("parser result with no room in the output stage");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the serial packet deframer
// Drives received bytes and line timeouts through the request channel,
// mirrors the framing rules in a local predictor and compares every result
// field by field. The node address is changed between traffic phases over the
// configuration port, and both channels stall at random.
// ----------------------------------------------------------------------------
module testbench
  import spd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BODY_LIMIT     = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int FAULT_SHOWN    = 10;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    SEEK_SYNC,
    GET_ADDR,
    GET_KIND,
    GET_BODY,
    GET_ESCAPED
  } parse_e;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  serial_packet_deframer #(
    .MAX_BODY(BODY_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: a private mirror of the deframer, advanced once per
  // accepted request.
  logic [7:0]  p_node      = '0;
  parse_e      p_phase     = SEEK_SYNC;
  logic [1:0]  p_syncs     = '0;
  logic        p_mid_frame = 1'b0;
  int          p_body_len  = 0;
  logic [7:0]  p_addr      = '0;
  logic [7:0]  p_kind      = '0;
  logic [7:0]  p_dly_hi    = '0;
  logic [7:0]  p_dly_lo    = '0;
  logic [15:0] p_delay     = '0;

  out_t        due_results[$];   // results predicted but not yet seen
  int          fault_count    = 0;
  int          requests_sent  = 0;
  int          quiet_cycles   = 0;
  bit          no_stalls      = 1'b0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Any end of frame, good or bad, sends the parser back to hunting.
  function automatic void close_frame();
    p_phase     = SEEK_SYNC;
    p_syncs     = '0;
    p_mid_frame = 1'b0;
    p_body_len  = 0;
  endfunction

  function automatic void raise_error(input logic [1:0] code);
    out_t r;
    r            = '0;
    r.result_kind = KIND_ERROR;
    r.tx_delay   = p_delay;
    r.error_code = code;
    due_results.push_back(r);
    close_frame();
  endfunction

  // Emit one body byte; body bytes 1 and 2 are the candidate delay.
  function automatic void push_body_byte(input logic [7:0] b);
    out_t r;
    r            = '0;
    r.result_kind = KIND_DATA;
    r.data_byte  = b;
    r.byte_index = 6'(p_body_len);
    r.tx_delay   = p_delay;
    due_results.push_back(r);
    if (p_body_len == 1) p_dly_hi = b;
    if (p_body_len == 2) p_dly_lo = b;
    p_body_len++;
    p_phase = GET_BODY;
  endfunction

  function automatic void predict_request(input in_t req);
    out_t r;
    logic mine;
    // A timeout only matters once bytes have been taken since the last end.
    if (req.req_type == REQ_TIMEOUT) begin
      if (p_mid_frame) raise_error(ERR_TIMEOUT);
      return;
    end
    p_mid_frame = 1'b1;
    case (p_phase)
      SEEK_SYNC: begin
        if (req.rx_byte == SYN_BYTE) begin
          if (p_syncs < 2) p_syncs++;
        end else if (p_syncs < 2) begin
          p_syncs = '0;                    // too few syncs: drop the byte
        end else if (req.rx_byte != STX_BYTE) begin
          raise_error(ERR_NO_STX);
        end else begin
          p_syncs    = '0;
          p_dly_hi   = '0;
          p_dly_lo   = '0;
          p_body_len = 0;
          p_phase    = GET_ADDR;
        end
      end
      GET_ADDR: begin
        p_addr  = req.rx_byte - ADDR_BASE;
        p_phase = GET_KIND;
      end
      GET_KIND: begin
        p_kind  = req.rx_byte;
        p_phase = GET_BODY;
      end
      GET_BODY: begin
        if (req.rx_byte == ETX_BYTE) begin
          mine = (p_addr == p_node);
          if (mine && p_kind == TYPE_INIT) p_delay = {p_dly_hi, p_dly_lo};
          r                = '0;
          r.result_kind    = KIND_COMPLETE;
          r.packet_address = p_addr;
          r.packet_type    = p_kind;
          r.body_length    = 7'(p_body_len);
          r.for_this_node  = mine;
          r.reply_needed   = mine && (p_kind == TYPE_POLL);
          r.tx_delay       = p_delay;
          due_results.push_back(r);
          close_frame();
        end else if (p_body_len >= BODY_LIMIT) begin
          raise_error(ERR_OVERFLOW);      // checked ahead of the escape
        end else if (req.rx_byte == DLE_BYTE) begin
          p_phase = GET_ESCAPED;
        end else begin
          push_body_byte(req.rx_byte);
        end
      end
      GET_ESCAPED: push_body_byte(req.rx_byte);
      default: close_frame();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic string describe_result(input out_t r);
    return $sformatf({"kind=%0d data=%02h idx=%0d addr=%02h type=%02h len=%0d",
                      " mine=%0b reply=%0b delay=%04h err=%0d"},
                     r.result_kind, r.data_byte, r.byte_index, r.packet_address,
                     r.packet_type, r.body_length, r.for_this_node, r.reply_needed,
                     r.tx_delay, r.error_code);
  endfunction

  function automatic bit result_matches(input out_t want, input out_t got);
    return (got.result_kind    === want.result_kind)
        && (got.data_byte      === want.data_byte)
        && (got.byte_index     === want.byte_index)
        && (got.packet_address === want.packet_address)
        && (got.packet_type    === want.packet_type)
        && (got.body_length    === want.body_length)
        && (got.for_this_node  === want.for_this_node)
        && (got.reply_needed   === want.reply_needed)
        && (got.tx_delay       === want.tx_delay)
        && (got.error_code     === want.error_code);
  endfunction

  // Show the first few faults in full, count the rest quietly.
  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= FAULT_SHOWN) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_fault($sformatf("unexpected result %s", describe_result(out_data)));
      end else begin
        want = due_results.pop_front();
        if (!result_matches(want, out_data))
          report_fault($sformatf("expected %s / actual %s",
                                 describe_result(want), describe_result(out_data)));
      end
    end
  end

  // Watchdog: give up once nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Result side back-pressure: stall with a chance of about three in ten unless the
  // current phase runs flat out.
  always @(negedge clk) begin
    out_ready <= no_stalls || ($urandom_range(0, 99) >= 30);
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request, hold it until taken, then advance the predictor.
  // Entered and left just after a falling edge; valid stays high on return.
  task automatic send_request(input in_t req);
    if (!no_stalls) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_request(req);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t req;
    req.req_type = REQ_BYTE;
    req.rx_byte  = b;
    send_request(req);
  endtask

  // The byte lane is don't-care on a timeout, so fill it with noise.
  task automatic send_timeout();
    in_t req;
    req.req_type = REQ_TIMEOUT;
    req.rx_byte  = 8'($urandom);
    send_request(req);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drop valid and wait until the block has gone quiet.
  task automatic settle_idle(input int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Write the node address, then read it back.
  task automatic write_node_address(input logic [7:0] value);
    logic [31:0] got;
    settle_idle(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_NODE_ADDRESS);
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    p_node = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[7:0] !== value)
      report_fault($sformatf("node address read back %02h, wrote %02h", got[7:0], value));
  endtask

  // --------------------------------------------------------------------------
  // Random field pickers
  // --------------------------------------------------------------------------

  // Half the frames target this node, so addressing and replies both show.
  function automatic logic [7:0] pick_address();
    if ($urandom_range(0, 1) == 0) return p_node + ADDR_BASE;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 4))
      0:       return TYPE_INIT;
      1:       return TYPE_POLL;
      2:       return 8'h54;            // transmit
      3:       return 8'h52;            // receive
      default: return 8'($urandom);
    endcase
  endfunction

  // Bias the body towards the framing bytes so escapes get exercised.
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(0, 9))
      0:       return ETX_BYTE;
      1:       return DLE_BYTE;
      2:       return SYN_BYTE;
      3:       return STX_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short bodies, a few long ones, now and then past the limit.
  function automatic int pick_body_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 6);
    if (roll < 95) return $urandom_range(7, 40);
    return $urandom_range(BODY_LIMIT - 4, BODY_LIMIT + 2);
  endfunction

  // Send one frame: syncs, STX, address, type, escaped body, optional ETX.
  task automatic send_frame(input logic [7:0] addr_byte, input logic [7:0] kind_byte,
                            input int body_len, input bit close);
    logic [7:0] b;
    repeat ($urandom_range(2, 4)) send_byte(SYN_BYTE);
    send_byte(STX_BYTE);
    send_byte(addr_byte);
    send_byte(kind_byte);
    repeat (body_len) begin
      b = pick_body_byte();
      // ETX and DLE must be escaped; escape other bytes once in a while too
      if (b == ETX_BYTE || b == DLE_BYTE || $urandom_range(0, 19) == 0)
        send_byte(DLE_BYTE);
      send_byte(b);
    end
    if (close) send_byte(ETX_BYTE);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-built frames for each framing rule, node address at zero.
  task automatic test_framing_cases();
    logic [7:0] frame[$];
    write_node_address(8'h00);
    // idle timeout: nothing consumed yet, so no result
    send_timeout();
    // a lone sync then a stray byte: drop it and keep hunting
    frame = '{SYN_BYTE, 8'h00};
    send_bytes(frame);
    // those bytes count, so the timeout now reports an error
    send_timeout();
    // enough syncs but no STX
    frame = '{SYN_BYTE, SYN_BYTE, 8'h55};
    send_bytes(frame);
    // poll to this node with escaped ETX and DLE and extreme byte values
    frame = '{SYN_BYTE, SYN_BYTE, SYN_BYTE, STX_BYTE, ADDR_BASE, TYPE_POLL,
              DLE_BYTE, ETX_BYTE, 8'h00, DLE_BYTE, DLE_BYTE, 8'hFF, ETX_BYTE};
    send_bytes(frame);
    // short init: the low delay byte is missing and reads as zero
    frame = '{SYN_BYTE, SYN_BYTE, STX_BYTE, ADDR_BASE, TYPE_INIT, 8'h00, 8'hAB,
              ETX_BYTE};
    send_bytes(frame);
  endtask

  // Fill the body to the limit, then run one byte past it.
  task automatic test_body_limits();
    send_frame(p_node + ADDR_BASE, TYPE_INIT, BODY_LIMIT, 1'b1);
    send_frame(pick_address(), pick_kind(), BODY_LIMIT, 1'b0);
    // a DLE at the overflow point still overflows; the ETX after it is noise
    send_byte(DLE_BYTE);
    send_byte(ETX_BYTE);
  endtask

  // Mostly good frames with random content; the rest is cut-short frames,
  // missing STX and plain line noise.
  task automatic test_random_traffic(input logic [7:0] node, input bit flat_out,
                                     input int budget);
    int stop_at;
    int shape;
    int cut;
    write_node_address(node);
    no_stalls = flat_out;
    stop_at   = requests_sent + budget;
    while (requests_sent < stop_at) begin
      shape = $urandom_range(0, 99);
      if (shape < 70) begin
        send_frame(pick_address(), pick_kind(), pick_body_length(), 1'b1);
      end else if (shape < 80) begin
        // stop somewhere in the frame and let the line time out
        cut = $urandom_range(0, 3);
        if (cut == 3) begin
          send_frame(pick_address(), pick_kind(), $urandom_range(0, 5), 1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) send_byte(SYN_BYTE);
          if (cut > 0) send_byte(STX_BYTE);
          if (cut > 1) send_byte(pick_address());
        end
        send_timeout();
      end else if (shape < 90) begin
        repeat ($urandom_range(2, 4)) send_byte(SYN_BYTE);
        send_byte(8'($urandom_range(3, 254)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) send_timeout();
          else send_byte(8'($urandom));
        end
        send_timeout();
      end
    end
    no_stalls = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_framing_cases();
    test_body_limits();
    test_random_traffic(8'hFF, 1'b0, 560);
    test_random_traffic(8'($urandom), 1'b1, 560);
    test_random_traffic(8'($urandom), 1'b0, 560);

    // Hold off until the last result is in, then leave room for strays.
    settle_idle(DRAIN_CYCLES);
    fault_count += due_results.size();
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[serial_packet_deframer.f]
src/spd_pkg.sv
src/spd_parser.sv
src/serial_packet_deframer.sv
tb/sv/testbench.sv
